FILE: design/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and the CRC-8 byte update for the frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int WORD_W   = 16;
	localparam int CENTI_W  = 18;
	localparam int TPROD_W  = 31;  // 65535 * 17500 fits in 31 bits
	localparam int HPROD_W  = 30;  // 65535 * 10000 fits in 30 bits
	localparam int QUO_W    = 16;

	localparam logic [7:0]         CRC_POLY   = 8'h31;
	localparam logic [7:0]         CRC_INIT   = 8'hFF;
	localparam logic [WORD_W-1:0]  WORD_ONES  = 16'hFFFF;
	localparam logic [14:0]        TEMP_SCALE = 15'd17500;
	localparam logic [13:0]        HUM_SCALE  = 14'd10000;
	localparam logic signed [CENTI_W-1:0] TEMP_OFFSET = 18'sd4500;
	localparam logic signed [CENTI_W-1:0] TEMP_BAD    = -18'sd99990;
	localparam logic signed [CENTI_W-1:0] HUM_BAD     = -18'sd99999;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_READ_FAIL = 3'd1,
		ST_CRC_W0    = 3'd2,
		ST_CRC_W1    = 3'd3,
		ST_CRC_W2    = 3'd4,
		ST_UNKNOWN   = 3'd5
	} status_t;

	// first failing word: none, or word 0/1/2
	typedef enum logic [1:0] {
		FAIL_NONE = 2'd0,
		FAIL_W0   = 2'd1,
		FAIL_W1   = 2'd2,
		FAIL_W2   = 2'd3
	} fail_t;

	typedef struct packed {
		logic                valid_res;
		status_t             status;
		logic [WORD_W-1:0]   co2_ppm;
		logic [WORD_W-1:0]   temp_raw;
		logic [WORD_W-1:0]   hum_raw;
		logic [TPROD_W-1:0]  tprod;
		logic [HPROD_W-1:0]  hprod;
	} sfc_res_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/sfc_frame.sv
// ----------------------------------------------------------------------------
// sfc_frame
// Byte position tracking, CRC check and word capture; loads the first result
// stage with status, words and the scaling products.
// ----------------------------------------------------------------------------
module sfc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  logic              frame_start,
	input  logic              read_error,
	input  logic              drain,
	output logic              v_s1,
	output sfc_pkg::sfc_res_t res_s1
);
	import sfc_pkg::*;

	logic [3:0]        idx_q;
	logic [7:0]        crc_q;
	fail_t             fail_q;
	logic [7:0]        pend_q;
	logic [WORD_W-1:0] w0_q, w1_q, w2_q;

	logic [3:0]        idx_e;
	logic [7:0]        crc_e, crc_upd;
	fail_t             fail_e, fail_n;
	logic [3:0]        idx_n;
	logic [7:0]        crc_n;
	logic              wr_w0, wr_w1, wr_w2, wr_pend;
	logic              last_byte, emit;
	logic [WORD_W-1:0] new_word;
	sfc_res_t          res_n;

	// a start flag, or a stale count, restarts the frame
	always_comb begin
		if (frame_start || idx_q > 4'd8) begin
			idx_e  = 4'd0;
			crc_e  = CRC_INIT;
			fail_e = FAIL_NONE;
		end else begin
			idx_e  = idx_q;
			crc_e  = crc_q;
			fail_e = fail_q;
		end
	end

	assign crc_upd  = crc8_byte(crc_e, rx_byte);
	assign new_word = {pend_q, rx_byte};

	always_comb begin
		wr_pend = 1'b0;
		wr_w0   = 1'b0;
		wr_w1   = 1'b0;
		wr_w2   = 1'b0;
		crc_n   = crc_upd;
		fail_n  = fail_e;
		unique case (idx_e)
			4'd0, 4'd3, 4'd6: wr_pend = 1'b1;
			4'd1: wr_w0 = 1'b1;
			4'd4: wr_w1 = 1'b1;
			4'd7: wr_w2 = 1'b1;
			4'd2: begin
				crc_n = CRC_INIT;
				if (crc_e != rx_byte && fail_e == FAIL_NONE) fail_n = FAIL_W0;
			end
			4'd5: begin
				crc_n = CRC_INIT;
				if (crc_e != rx_byte && fail_e == FAIL_NONE) fail_n = FAIL_W1;
			end
			4'd8: begin
				crc_n = CRC_INIT;
				if (crc_e != rx_byte && fail_e == FAIL_NONE) fail_n = FAIL_W2;
			end
			default: crc_n = CRC_INIT;
		endcase
	end

	assign last_byte = (idx_e == 4'd8);
	assign emit      = read_error || last_byte;
	assign idx_n     = last_byte ? 4'd0 : idx_e + 4'd1;

	always_comb begin
		res_n.valid_res = 1'b0;
		res_n.status    = ST_OK;
		res_n.co2_ppm   = WORD_ONES;
		res_n.temp_raw  = WORD_ONES;
		res_n.hum_raw   = WORD_ONES;
		res_n.tprod     = TPROD_W'(w1_q) * TPROD_W'(TEMP_SCALE);
		res_n.hprod     = HPROD_W'(w2_q) * HPROD_W'(HUM_SCALE);
		if (read_error) begin
			res_n.status = ST_READ_FAIL;
		end else begin
			unique case (fail_n)
				FAIL_W0: res_n.status = ST_CRC_W0;
				FAIL_W1: res_n.status = ST_CRC_W1;
				FAIL_W2: res_n.status = ST_CRC_W2;
				FAIL_NONE: begin
					res_n.co2_ppm  = w0_q;
					res_n.temp_raw = w1_q;
					res_n.hum_raw  = w2_q;
					if (w0_q == WORD_ONES || w1_q == WORD_ONES || w2_q == WORD_ONES) begin
						res_n.status = ST_UNKNOWN;
					end else begin
						res_n.valid_res = 1'b1;
						res_n.status    = ST_OK;
					end
				end
				default: res_n.status = ST_READ_FAIL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 4'd0;
			crc_q  <= CRC_INIT;
			fail_q <= FAIL_NONE;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				if (read_error) begin
					idx_q  <= 4'd0;
					crc_q  <= CRC_INIT;
					fail_q <= FAIL_NONE;
				end else begin
					idx_q  <= idx_n;
					crc_q  <= crc_n;
					fail_q <= last_byte ? FAIL_NONE : fail_n;
				end
			end
			if (accept && emit) begin
				v_s1 <= 1'b1;
			end else if (drain) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !read_error) begin
			if (wr_pend) pend_q <= rx_byte;
			if (wr_w0)   w0_q   <= new_word;
			if (wr_w1)   w1_q   <= new_word;
			if (wr_w2)   w2_q   <= new_word;
		end
		if (accept && emit) begin
			res_s1 <= res_n;
		end
	end

endmodule

FILE: design/sfc_scale.sv
// ----------------------------------------------------------------------------
// sfc_scale
// Output stage: divides the scaling products by 65535, applies the offset and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module sfc_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_s1,
	input  sfc_pkg::sfc_res_t                 res_s1,
	input  logic                              out_stall,
	output logic                              drain,
	output logic                              out_valid,
	output logic                              valid_res,
	output logic [2:0]                        status,
	output logic [sfc_pkg::WORD_W-1:0]        co2_ppm,
	output logic [sfc_pkg::WORD_W-1:0]        temp_raw,
	output logic [sfc_pkg::WORD_W-1:0]        hum_raw,
	output logic signed [sfc_pkg::CENTI_W-1:0] temp_centi,
	output logic signed [sfc_pkg::CENTI_W-1:0] hum_centi
);
	import sfc_pkg::*;

	logic [31:0]               tsum, hsum;
	logic [QUO_W-1:0]          tquo, hquo;
	logic signed [CENTI_W-1:0] temp_n, hum_n;

	// floor(x/65535) = floor((x + floor(x/65536) + 1) / 65536) while x/65535 <= 65536
	assign tsum = 32'(res_s1.tprod) + 32'(res_s1.tprod >> 16) + 32'd1;
	assign hsum = 32'(res_s1.hprod) + 32'(res_s1.hprod >> 16) + 32'd1;
	assign tquo = tsum[31:16];
	assign hquo = hsum[31:16];

	assign temp_n = res_s1.valid_res ? $signed({2'b00, tquo}) - TEMP_OFFSET : TEMP_BAD;
	assign hum_n  = res_s1.valid_res ? $signed({2'b00, hquo}) : HUM_BAD;

	assign drain = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (drain) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain && v_s1) begin
			valid_res  <= res_s1.valid_res;
			status     <= res_s1.status;
			co2_ppm    <= res_s1.co2_ppm;
			temp_raw   <= res_s1.temp_raw;
			hum_raw    <= res_s1.hum_raw;
			temp_centi <= temp_n;
			hum_centi  <= hum_n;
		end
	end

endmodule

FILE: design/sensor_response_frame_checker.sv
// ----------------------------------------------------------------------------
// sensor_response_frame_checker
// Checks a nine-byte sensor measurement response and converts its words.
//
// Input channel (in_valid/in_stall): one response byte per transfer with
// frame_start and read_error flags. Every byte advances the frame state in
// the cycle it is taken; one byte per clock is sustained while in_stall is low.
// Output channel (out_valid/out_stall): one result per completed frame or per
// read error, carrying status, the three words and scaled temperature and
// humidity. A result from the ninth byte (or the failed byte) passes a
// check/multiply stage, then a divide/offset output register, to out_valid.
// While the output is stalled, bytes keep being taken until a second result
// waits; in_stall rises only when both result stages are full and out_stall
// is high, and then holds every byte, result or not.
// Reset clears the byte count, CRC and failure record and empties both
// stages; word registers are loaded as bytes arrive.
// ----------------------------------------------------------------------------
module sensor_response_frame_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         rx_byte,
	input  logic                               frame_start,
	input  logic                               read_error,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               valid_res,
	output logic [2:0]                         status,
	output logic [sfc_pkg::WORD_W-1:0]         co2_ppm,
	output logic [sfc_pkg::WORD_W-1:0]         temp_raw,
	output logic [sfc_pkg::WORD_W-1:0]         hum_raw,
	output logic signed [sfc_pkg::CENTI_W-1:0] temp_centi,
	output logic signed [sfc_pkg::CENTI_W-1:0] hum_centi
);
	import sfc_pkg::*;

	logic     accept;
	logic     drain;
	logic     v_s1;
	sfc_res_t res_s1;

	assign in_stall = v_s1 && !drain;
	assign accept   = in_valid && !in_stall;

	sfc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.read_error (read_error),
		.drain      (drain),
		.v_s1       (v_s1),
		.res_s1     (res_s1)
	);

	sfc_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s1       (v_s1),
		.res_s1     (res_s1),
		.out_stall  (out_stall),
		.drain      (drain),
		.out_valid  (out_valid),
		.valid_res  (valid_res),
		.status     (status),
		.co2_ppm    (co2_ppm),
		.temp_raw   (temp_raw),
		.hum_raw    (hum_raw),
		.temp_centi (temp_centi),
		.hum_centi  (hum_centi)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked output");

	a_read_err: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && read_error) |=> (v_s1 && res_s1.status == ST_READ_FAIL))
		else $error("read error did not produce a read-fail result");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res) |-> (status == ST_OK))
		else $error("valid result with non-ok status");

	a_bad_centi: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (temp_centi == TEMP_BAD && hum_centi == HUM_BAD))
		else $error("invalid result with converted values");

endmodule

FILE: test/tb_sensor_response_frame_checker.sv
// ----------------------------------------------------------------------------
// tb_sensor_response_frame_checker
// Drives nine-byte sensor responses (good frames, CRC failures, all-ones
// words, read errors, restarts, noise) through the frame checker and compares
// every result with a cycle-free model of the frame state kept in the bench.
// ----------------------------------------------------------------------------
module tb_sensor_response_frame_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import sfc_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic                      vres;
		status_t                   st;
		logic [WORD_W-1:0]         co2;
		logic [WORD_W-1:0]         traw;
		logic [WORD_W-1:0]         hraw;
		logic signed [CENTI_W-1:0] tcenti;
		logic signed [CENTI_W-1:0] hcenti;
	} reading_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [7:0]                 rx_byte;
	logic                       frame_start;
	logic                       read_error;
	logic                       out_valid;
	logic                       out_stall;
	logic                       valid_res;
	logic [2:0]                 status;
	logic [WORD_W-1:0]          co2_ppm;
	logic [WORD_W-1:0]          temp_raw;
	logic [WORD_W-1:0]          hum_raw;
	logic signed [CENTI_W-1:0]  temp_centi;
	logic signed [CENTI_W-1:0]  hum_centi;

	// frame state as the bench tracks it
	logic [3:0]         pos;
	logic [7:0]         crc_acc;
	logic [7:0]         hi_byte;
	logic [WORD_W-1:0]  words [3];
	fail_t              first_bad;

	reading_t     pending_readings [$];
	int unsigned  items_sent;
	int unsigned  err_cnt;
	int unsigned  stuck_cycles;
	logic         steady;

	sensor_response_frame_checker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.read_error (read_error),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.valid_res  (valid_res),
		.status     (status),
		.co2_ppm    (co2_ppm),
		.temp_raw   (temp_raw),
		.hum_raw    (hum_raw),
		.temp_centi (temp_centi),
		.hum_centi  (hum_centi)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// serial form: one data bit at a time into the feedback
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb  = acc[7] ^ d[k];
			acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return acc;
	endfunction

	function automatic logic [7:0] word_crc(input logic [WORD_W-1:0] w);
		return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	// nine response bytes; bad[k] spoils the CRC of word k
	function automatic logic [71:0] frame_bytes(input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
			input logic [2:0] bad);
		logic [7:0] c0, c1, c2;
		c0 = word_crc(w0) ^ (bad[0] ? 8'($urandom_range(1, 255)) : 8'h00);
		c1 = word_crc(w1) ^ (bad[1] ? 8'($urandom_range(1, 255)) : 8'h00);
		c2 = word_crc(w2) ^ (bad[2] ? 8'($urandom_range(1, 255)) : 8'h00);
		return {w0, c0, w1, c1, w2, c2};
	endfunction

	task automatic clear_frame();
		pos       = 4'd0;
		crc_acc   = CRC_INIT;
		first_bad = FAIL_NONE;
	endtask

	task automatic push_reading(input logic v, input status_t st, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic signed [CENTI_W-1:0] tc, input logic signed [CENTI_W-1:0] hc);
		reading_t r;
		r.vres   = v;
		r.st     = st;
		r.co2    = a;
		r.traw   = b;
		r.hraw   = c;
		r.tcenti = tc;
		r.hcenti = hc;
		pending_readings.push_back(r);
	endtask

	// advance the tracked frame by one accepted byte, queue any result
	task automatic track_byte(input logic [7:0] b, input logic st, input logic re);
		int unsigned tprod, hprod;
		int          tc, hc;
		status_t     crc_st;
		if (re) begin
			clear_frame();
			push_reading(1'b0, ST_READ_FAIL, WORD_ONES, WORD_ONES, WORD_ONES, TEMP_BAD, HUM_BAD);
		end else begin
			if (st || pos > 4'd8)
				clear_frame();
			case (pos % 3)
				0: begin
					hi_byte = b;
					crc_acc = crc8_step(crc_acc, b);
				end
				1: begin
					words[pos / 3] = {hi_byte, b};
					crc_acc = crc8_step(crc_acc, b);
				end
				default: begin
					if (crc_acc != b && first_bad == FAIL_NONE) begin
						case (pos / 3)
							0:       first_bad = FAIL_W0;
							1:       first_bad = FAIL_W1;
							default: first_bad = FAIL_W2;
						endcase
					end
					crc_acc = CRC_INIT;
				end
			endcase
			if (pos < 4'd8) begin
				pos = pos + 4'd1;
			end else begin
				if (first_bad != FAIL_NONE) begin
					case (first_bad)
						FAIL_W0: crc_st = ST_CRC_W0;
						FAIL_W1: crc_st = ST_CRC_W1;
						default: crc_st = ST_CRC_W2;
					endcase
					push_reading(1'b0, crc_st, WORD_ONES, WORD_ONES, WORD_ONES,
						TEMP_BAD, HUM_BAD);
				end else if (words[0] == WORD_ONES || words[1] == WORD_ONES ||
						words[2] == WORD_ONES) begin
					push_reading(1'b0, ST_UNKNOWN, words[0], words[1], words[2],
						TEMP_BAD, HUM_BAD);
				end else begin
					tprod = words[1] * 32'd17500;
					hprod = words[2] * 32'd10000;
					tc    = int'(tprod / 32'd65535) - 4500;
					hc    = int'(hprod / 32'd65535);
					push_reading(1'b1, ST_OK, words[0], words[1], words[2],
						CENTI_W'(tc), CENTI_W'(hc));
				end
				clear_frame();
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st, input logic re);
		while (!steady && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= st;
		read_error  <= re;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_byte(b, st, re);
		items_sent++;
	endtask

	// first n bytes of a frame; frame_start only on the first
	task automatic send_frame(input logic [71:0] fb, input int unsigned n, input logic st);
		for (int k = 0; k < n; k++)
			send_byte(fb[71 - 8*k -: 8], (k == 0) ? st : 1'b0, 1'b0);
	endtask

	task automatic test_restart_mid_frame();
		send_byte(8'($urandom), 1'b1, 1'b0);
		send_byte(8'($urandom), 1'b0, 1'b0);
		send_frame(frame_bytes(16'h0000, 16'hFFFE, 16'h0000, 3'b000), 9, 1'b1);
	endtask

	// follows a complete frame with no frame_start; all-ones hum word
	task automatic test_wrap_unknown_value();
		send_frame(frame_bytes(16'h1234, 16'h8000, WORD_ONES, 3'b000), 9, 1'b0);
	endtask

	task automatic test_read_error();
		send_byte(8'($urandom), 1'b1, 1'b0);
		send_byte(8'($urandom), 1'b1, 1'b1);
	endtask

	// words 1 and 2 both fail, word 1 must be reported
	task automatic test_crc_first_fail();
		send_frame(frame_bytes(16'h0400, 16'h6666, 16'h9999, 3'b110), 9, 1'b0);
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_readings.size() != 0);
	endtask

	task automatic test_random_frames(input int unsigned n_items);
		int unsigned     base, cut;
		logic [WORD_W-1:0] w [3];
		logic [2:0]      bad;
		logic [71:0]     fb;
		logic            st, need_start;
		base       = items_sent;
		need_start = 1'b1;
		while (items_sent < base + n_items) begin
			steady = (items_sent >= base + n_items / 3) && (items_sent < base + n_items / 2);
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(9))
					0:       w[k] = 16'h0000;
					1:       w[k] = WORD_ONES;
					2:       w[k] = 16'hFFFE;
					default: w[k] = 16'($urandom);
				endcase
				bad[k] = ($urandom_range(99) < 8);
			end
			fb         = frame_bytes(w[0], w[1], w[2], bad);
			st         = need_start || ($urandom_range(3) != 0);
			need_start = 1'b0;
			case ($urandom_range(19))
				0: begin
					// truncated, next frame restarts it
					send_frame(fb, $urandom_range(1, 8), st);
					need_start = 1'b1;
				end
				1: begin
					cut = $urandom_range(0, 8);
					send_frame(fb, cut, st);
					send_byte(8'($urandom), 1'($urandom), 1'b1);
				end
				2: begin
					repeat ($urandom_range(1, 4))
						send_byte(8'($urandom), 1'($urandom), $urandom_range(7) == 0);
					need_start = 1'b1;
				end
				default: send_frame(fb, 9, st);
			endcase
		end
		steady = 1'b0;
	endtask

	task automatic check_reading();
		reading_t e;
		if (pending_readings.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("unexpected result: status %0d co2 %h", status, co2_ppm);
		end else begin
			e = pending_readings.pop_front();
			if (valid_res !== e.vres || status !== e.st || co2_ppm !== e.co2 ||
					temp_raw !== e.traw || hum_raw !== e.hraw ||
					temp_centi !== e.tcenti || hum_centi !== e.hcenti) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS) begin
					$display("mismatch exp: v %b st %0d %h %h %h t %0d h %0d", e.vres, e.st,
						e.co2, e.traw, e.hraw, e.tcenti, e.hcenti);
					$display("         got: v %b st %0d %h %h %h t %0d h %0d", valid_res,
						status, co2_ppm, temp_raw, hum_raw, temp_centi, hum_centi);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_reading();
			out_stall <= !steady && ($urandom_range(99) < 28);
		end
	end

	// no transfer on either side for too long: hung
	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles = 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb_sensor_response_frame_checker: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		rx_byte     <= 8'h00;
		frame_start <= 1'b0;
		read_error  <= 1'b0;
		steady       = 1'b0;
		items_sent   = 0;
		err_cnt      = 0;
		words[0]     = '0;
		words[1]     = '0;
		words[2]     = '0;
		hi_byte      = '0;
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_restart_mid_frame();
		test_wrap_unknown_value();
		test_read_error();
		test_crc_first_fail();
		test_drain_pause();
		test_random_frames(375);
		test_drain_pause();
		test_random_frames(375);

		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && pending_readings.size() == 0)
			$display("tb_sensor_response_frame_checker: PASS");
		else
			$display("tb_sensor_response_frame_checker: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
design/sfc_pkg.sv
design/sfc_frame.sv
design/sfc_scale.sv
design/sensor_response_frame_checker.sv
test/tb_sensor_response_frame_checker.sv
